// File: rtl/bpspd_pkg.sv
`timescale 1ns / 1ps
package bpspd_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_PORT_WR = 2'd0,
    REQ_PORT_RD = 2'd1,
    REQ_MAP_QRY = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_kind_t;

  // Result data source carried in the output tuser
  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_SOUND    = 2'd1,
    SRC_ULA      = 2'd2,
    SRC_FLOATING = 2'd3
  } data_src_t;

  // Port decode masks and matches
  localparam logic [15:0] PAGING_PORT_MASK  = 16'h8002;
  localparam logic [15:0] SOUND_PORT_MASK   = 16'hC002;
  localparam logic [15:0] SOUND_SELECT_PORT = 16'h8000;
  localparam logic [15:0] SOUND_DATA_PORT   = 16'hC000;

  // Paging register bit positions
  localparam int LOCK_BIT     = 5;
  localparam int ROM_BANK_BIT = 4;
  localparam int VIDEO_BIT    = 3;

  // Fixed RAM banks of the middle slots
  localparam logic [2:0] SLOT1_BANK = 3'd5;
  localparam logic [2:0] SLOT2_BANK = 3'd2;

  // Packed widths on the stream ports
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

endpackage

// File: rtl/bank_paging_and_sound_port_decoder.sv
`timescale 1ns / 1ps
// Bank paging and sound port decoder.
// Input channel (in_*): one bus request per word. in_tuser holds the request
// kind (port write, port read, memory map query); in_tdata holds the 16-bit
// bus address and the write byte.
// Output channel (out_*): one result word per request. out_tuser holds the
// data source; out_tdata holds the read byte, the map query answer and the
// current display page and lock status.
// A request is latched when it is accepted; its result word is loaded into
// the output register when the execute step ends, and is valid from then on.
// The block takes no new request until the execute step of the previous one
// ends; the sound register file is a synchronous RAM, read when a request is
// accepted and written back when its execute step ends.
// The block takes a new request while the previous result still waits in the
// output register; if that register is full when the execute cycle ends, the
// execute step holds until the receiver takes the pending word.
// Reset clears the paging register, its lock, the register select and the
// valid bits of the sound registers, so every sound register reads as zero
// until written. No clearing pass is needed.
module bank_paging_and_sound_port_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] bus_address, [23:16] write_data
  input  logic [bpspd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] req_type
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] read_data, [8] is_rom, [11:9] mapped_bank, [12] slot_writable,
  // [13] video_alt_bank, [14] paging_is_locked, [15] zero
  output logic [bpspd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] data_source
  output logic [1:0]                          out_tuser
);
  import bpspd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t      state_r, state_nxt;

  // Control state
  logic [5:0]  paging_r, paging_nxt;
  logic        lock_r, lock_nxt;
  logic [3:0]  sel_r, sel_nxt;
  logic [15:0] snd_valid_r;
  logic        out_valid_r;

  // Request and result payload
  logic [1:0]  req_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  rd_data_r;
  logic        rd_valid_r;
  logic [14:0] out_data_r;
  logic [1:0]  out_src_r;

  // Sound register file
  logic [7:0]  snd_mem [16];

  logic        accept;
  logic        out_free;
  logic        finish;
  logic        mem_we;
  logic [7:0]  snd_byte;
  logic [7:0]  res_rd;
  data_src_t   res_src;
  logic        res_rom;
  logic [2:0]  res_bank;
  logic        res_wr;
  logic        is_even;
  logic        hit_paging, hit_select, hit_data;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == ST_EXEC) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_src_r;

  // Decode the latched request
  assign is_even    = !addr_r[0];
  assign hit_paging = (addr_r & PAGING_PORT_MASK) == 16'h0000;
  assign hit_select = (addr_r & SOUND_PORT_MASK) == SOUND_SELECT_PORT;
  assign hit_data   = (addr_r & SOUND_PORT_MASK) == SOUND_DATA_PORT;
  assign snd_byte   = rd_valid_r ? rd_data_r : 8'h00;

  always_comb begin
    paging_nxt = paging_r;
    lock_nxt   = lock_r;
    sel_nxt    = sel_r;
    mem_we     = 1'b0;
    res_rd     = 8'h00;
    res_src    = SRC_NONE;
    res_rom    = 1'b0;
    res_bank   = 3'd0;
    res_wr     = 1'b0;
    case (req_kind_t'(req_r))
      REQ_PORT_WR: begin
        if (hit_paging) begin
          if (!lock_r) begin
            paging_nxt = wdata_r[5:0];
            lock_nxt   = wdata_r[LOCK_BIT];
          end
        end else if (is_even) begin
          res_src = SRC_ULA;
        end else if (hit_select) begin
          sel_nxt = wdata_r[3:0];
        end else if (hit_data) begin
          mem_we = 1'b1;
        end
      end
      REQ_PORT_RD: begin
        if (is_even) begin
          res_src = SRC_ULA;
        end else if (hit_data) begin
          res_rd  = snd_byte;
          res_src = SRC_SOUND;
        end else begin
          res_src = SRC_FLOATING;
        end
      end
      REQ_MAP_QRY: begin
        case (addr_r[15:14])
          2'b00: begin
            res_rom  = 1'b1;
            res_bank = {2'b00, paging_r[ROM_BANK_BIT]};
          end
          2'b01: begin
            res_wr   = 1'b1;
            res_bank = SLOT1_BANK;
          end
          2'b10: begin
            res_wr   = 1'b1;
            res_bank = SLOT2_BANK;
          end
          default: begin
            res_wr   = 1'b1;
            res_bank = paging_r[2:0];
          end
        endcase
      end
      default: begin
        res_src = SRC_NONE;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      paging_r    <= 6'd0;
      lock_r      <= 1'b0;
      sel_r       <= 4'd0;
      snd_valid_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        paging_r <= paging_nxt;
        lock_r   <= lock_nxt;
        sel_r    <= sel_nxt;
        if (mem_we) snd_valid_r[sel_r] <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the request and read the selected sound register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_tuser;
      addr_r     <= in_tdata[15:0];
      wdata_r    <= in_tdata[23:16];
      rd_data_r  <= snd_mem[sel_r];
      rd_valid_r <= snd_valid_r[sel_r];
    end
  end

  // Write back the sound register
  always_ff @(posedge clk) begin
    if (finish && mem_we) snd_mem[sel_r] <= wdata_r;
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {lock_nxt, paging_nxt[VIDEO_BIT], res_wr, res_bank, res_rom, res_rd};
      out_src_r  <= res_src;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bpspd_pkg::*;

  localparam logic [15:0] SLOT1_START = 16'h4000;
  localparam logic [15:0] SLOT2_START = 16'h8000;
  localparam logic [15:0] SLOT3_START = 16'hC000;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          PHASE_ITEMS = 125;

  // One decoded bus request as seen on the result channel
  typedef struct {
    logic [7:0] read_data;
    data_src_t  source;
    logic       is_rom;
    logic [2:0] bank;
    logic       writable;
    logic       video;
    logic       locked;
  } decode_word_t;

  // Shadow of the paging and sound state plus the words still owed by the block
  class decode_scoreboard;
    logic [5:0]   paging;
    logic         lock;
    logic [3:0]   select;
    logic [7:0]   sound_file [16];
    decode_word_t owed [$];
    int           errors;
    int           n_wr, n_rd, n_qry, n_unused, n_sound_rd, n_locked_wr;

    function new();
      paging = '0;
      lock   = 1'b0;
      select = '0;
      foreach (sound_file[i]) sound_file[i] = '0;
      errors = 0;
      n_wr = 0; n_rd = 0; n_qry = 0; n_unused = 0; n_sound_rd = 0; n_locked_wr = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report_mismatch(string what, int want, int got);
      errors++;
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Advance the shadow state by one accepted request and queue its word
    function void note_request(req_kind_t kind, logic [15:0] addr, logic [7:0] data);
      decode_word_t w;
      w.read_data = '0;
      w.source    = SRC_NONE;
      w.is_rom    = 1'b0;
      w.bank      = '0;
      w.writable  = 1'b0;
      case (kind)
        REQ_PORT_WR: begin
          n_wr++;
          if ((addr & PAGING_PORT_MASK) == 16'h0000) begin
            if (!lock) begin
              paging = data[5:0];
              lock   = data[LOCK_BIT];
            end else begin
              n_locked_wr++;
            end
          end else if (!addr[0]) begin
            w.source = SRC_ULA;
          end else if ((addr & SOUND_PORT_MASK) == SOUND_SELECT_PORT) begin
            select = data[3:0];
          end else if ((addr & SOUND_PORT_MASK) == SOUND_DATA_PORT) begin
            sound_file[select] = data;
          end
        end
        REQ_PORT_RD: begin
          n_rd++;
          if (!addr[0]) begin
            w.source = SRC_ULA;
          end else if ((addr & SOUND_PORT_MASK) == SOUND_DATA_PORT) begin
            w.read_data = sound_file[select];
            w.source    = SRC_SOUND;
            n_sound_rd++;
          end else begin
            w.source = SRC_FLOATING;
          end
        end
        REQ_MAP_QRY: begin
          n_qry++;
          if (addr < SLOT1_START) begin
            w.is_rom = 1'b1;
            w.bank   = {2'b00, paging[ROM_BANK_BIT]};
          end else begin
            w.writable = 1'b1;
            if (addr < SLOT2_START)      w.bank = SLOT1_BANK;
            else if (addr < SLOT3_START) w.bank = SLOT2_BANK;
            else                         w.bank = paging[2:0];
          end
        end
        default: n_unused++;
      endcase
      w.video  = paging[VIDEO_BIT];
      w.locked = lock;
      owed.push_back(w);
    endfunction

    // Compare one result word with the oldest owed word
    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser);
      decode_word_t w;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result word", 0, {tuser, tdata});
      end else begin
        w = owed.pop_front();
        if (tdata[7:0] !== w.read_data) report_mismatch("read_data", w.read_data, tdata[7:0]);
        if (tuser !== w.source)         report_mismatch("data_source", w.source, tuser);
        if (tdata[8] !== w.is_rom)      report_mismatch("is_rom", w.is_rom, tdata[8]);
        if (tdata[11:9] !== w.bank)     report_mismatch("mapped_bank", w.bank, tdata[11:9]);
        if (tdata[12] !== w.writable)   report_mismatch("slot_writable", w.writable, tdata[12]);
        if (tdata[13] !== w.video)      report_mismatch("video_alt_bank", w.video, tdata[13]);
        if (tdata[14] !== w.locked)     report_mismatch("paging_is_locked", w.locked, tdata[14]);
        if (tdata[15] !== 1'b0)         report_mismatch("tdata pad bit", 0, tdata[15]);
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  decode_scoreboard sb;

  bank_paging_and_sound_port_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note each accepted request word, check each accepted result word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(req_kind_t'(in_tuser), in_tdata[15:0], in_tdata[23:16]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // End the run when neither channel moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no word moved for %0d cycles", $realtime, IDLE_LIMIT);
    $display("bank_paging_and_sound_port_decoder regression: fail");
    $finish;
  end

  // Offer one request word, with random idle cycles ahead of it
  task automatic push_request(req_kind_t kind, logic [15:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly well-formed port and map traffic; a little pure noise
  task automatic random_request(bit allow_lock);
    req_kind_t   kind;
    logic [15:0] addr;
    logic [7:0]  data;
    int          pick;
    addr = 16'($urandom);
    data = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      kind = REQ_PORT_WR;
      addr[15] = 1'b0;
      addr[1]  = 1'b0;
      if (!allow_lock || $urandom_range(15) != 0) data[LOCK_BIT] = 1'b0;
    end else if (pick < 25) begin
      kind = REQ_PORT_WR;
      addr[0] = 1'b0;
      if ((addr & PAGING_PORT_MASK) == 16'h0000) begin
        if ($urandom_range(1)) addr[15] = 1'b1;
        else addr[1] = 1'b1;
      end
    end else if (pick < 38) begin
      kind = REQ_PORT_WR;
      addr[15:14] = 2'b10;
      addr[1:0]   = 2'b01;
    end else if (pick < 53) begin
      kind = REQ_PORT_WR;
      addr[15:14] = 2'b11;
      addr[1:0]   = 2'b01;
    end else if (pick < 58) begin
      kind = REQ_PORT_WR;
      addr[1:0] = 2'b11;
    end else if (pick < 73) begin
      kind = REQ_PORT_RD;
      addr[15:14] = 2'b11;
      addr[1:0]   = 2'b01;
    end else if (pick < 81) begin
      kind = REQ_PORT_RD;
    end else if (pick < 96) begin
      kind = REQ_MAP_QRY;
    end else begin
      kind = req_kind_t'($urandom_range(3));
    end
    // Keep the lock clear until the final phase
    if (!allow_lock && kind == REQ_PORT_WR && (addr & PAGING_PORT_MASK) == 16'h0000)
      data[LOCK_BIT] = 1'b0;
    push_request(kind, addr, data);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int send_pct [4];
    int recv_pct [4];
    sb = new();
    send_pct = '{0, 52, 0, 36};
    recv_pct = '{0, 0, 52, 36};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slot boundaries with the power-up map
    push_request(REQ_MAP_QRY, 16'h0000, 8'h00);
    push_request(REQ_MAP_QRY, 16'h3FFF, 8'hFF);
    push_request(REQ_MAP_QRY, 16'h4000, 8'h00);
    push_request(REQ_MAP_QRY, 16'h7FFF, 8'h00);
    push_request(REQ_MAP_QRY, 16'h8000, 8'h00);
    push_request(REQ_MAP_QRY, 16'hBFFF, 8'h00);
    push_request(REQ_MAP_QRY, 16'hC000, 8'h00);
    push_request(REQ_MAP_QRY, 16'hFFFF, 8'h00);
    // Sound register reads as zero after reset
    push_request(REQ_PORT_RD, 16'hC001, 8'h00);
    // Paging write with the upper data bits masked off, lock bit clear
    push_request(REQ_PORT_WR, 16'h7FFD, 8'hDF);
    push_request(REQ_MAP_QRY, 16'h0000, 8'h00);
    push_request(REQ_MAP_QRY, 16'hFFFF, 8'h00);
    push_request(REQ_PORT_WR, 16'h0000, 8'h00);
    // Register select and data, top entry and bottom entry
    push_request(REQ_PORT_WR, 16'hBFFD, 8'hFF);
    push_request(REQ_PORT_WR, 16'hFFFD, 8'hA5);
    push_request(REQ_PORT_RD, 16'hFFFD, 8'h00);
    push_request(REQ_PORT_WR, 16'h8001, 8'h00);
    push_request(REQ_PORT_RD, 16'hC001, 8'h00);
    // ULA port writes and read, odd undecoded port, floating bus reads
    push_request(REQ_PORT_WR, 16'h00FE, 8'hFF);
    push_request(REQ_PORT_WR, 16'hFFFE, 8'h5A);
    push_request(REQ_PORT_RD, 16'h00FE, 8'h00);
    push_request(REQ_PORT_WR, 16'hFFFF, 8'h55);
    push_request(REQ_PORT_RD, 16'h0001, 8'h00);
    push_request(REQ_PORT_RD, 16'hFFFF, 8'h00);
    // Unused request kind
    push_request(REQ_UNUSED, 16'hFFFF, 8'hFF);
    in_tvalid <= 1'b0;
    drain_results();

    // Random traffic over the idle settings; the lock may only set in the last
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) random_request(ph == 3);
      in_tvalid <= 1'b0;
      drain_results();
    end

    // Lock the paging register and try to move it afterwards
    push_request(REQ_PORT_WR, 16'h7FFD, 8'h3F);
    push_request(REQ_MAP_QRY, 16'hC000, 8'h00);
    push_request(REQ_PORT_WR, 16'h7FFD, 8'h00);
    push_request(REQ_MAP_QRY, 16'h0000, 8'h00);
    push_request(REQ_MAP_QRY, 16'hFFFF, 8'h00);
    push_request(REQ_PORT_WR, 16'hBFFD, 8'h03);
    push_request(REQ_PORT_WR, 16'hC001, 8'h80);
    push_request(REQ_PORT_RD, 16'hC001, 8'h00);
    in_tvalid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    if (sb.pending() != 0) sb.report_mismatch("result words never delivered", 0, sb.pending());
    $display("covered %0d port writes (%0d while locked), %0d port reads (%0d sound),",
             sb.n_wr, sb.n_locked_wr, sb.n_rd, sb.n_sound_rd);
    $display("%0d map queries and %0d unused requests over four idle settings",
             sb.n_qry, sb.n_unused);
    if (sb.errors == 0) begin
      $display("bank_paging_and_sound_port_decoder regression: pass");
    end else begin
      $display("bank_paging_and_sound_port_decoder regression: fail");
    end
    $finish;
  end

endmodule
